[rtl/core/lazy_free_list_entry_allocator_defines.svh]
// Assertion macros shared by the allocator RTL.
`ifndef LAZY_FREE_LIST_ENTRY_ALLOCATOR_DEFINES_SVH
`define LAZY_FREE_LIST_ENTRY_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define LFLA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LFLA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define LFLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LFLA_ASSERT(label, prop, msg)
`define LFLA_ASSERT_IMPL(label, ante, cons, msg)
`define LFLA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[rtl/core/lfla_pkg.sv]
`default_nettype none

package lfla_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  // An 8-bit index reaches at most 256 entries.
  localparam int LIMIT_CAP   = (MAX_ENTRIES > 256) ? 256 : MAX_ENTRIES;
  localparam int IDX_W       = 8;
  localparam int CNT_W       = 9;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_NONE  = 2'd3
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

endpackage

`default_nettype wire

[rtl/core/lazy_free_list_entry_allocator.sv]
// A request is accepted in S_IDLE, where the head link is read; in S_EXEC its result
// is registered once the output register is empty or its result is being taken.
// One request at a time: the block goes back to S_IDLE when the result is registered.
// A new request is taken while an earlier result still waits on the output.
// Reset: empty pool, pool size 256; the link memory is not cleared and needs no sweep.
`default_nettype none
`include "lazy_free_list_entry_allocator_defines.svh"

module lazy_free_list_entry_allocator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lfla_pkg::CNT_W-1:0]      cfg_wdata_i,   // entries_in_use
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [lfla_pkg::IDX_W-1:0]      s_axis_tdata,  // [7:0] free_index
  input  wire logic [0:0]                      s_axis_tuser,  // [0] req_type
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [23:0]                          m_axis_tdata,  // [7:0] entry_index,
                                                              // [16:8] allocated_count
  output logic [1:0]                           m_axis_tuser   // [1:0] status
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  localparam int CW = lfla_pkg::CNT_W;
  localparam int IW = lfla_pkg::IDX_W;
  localparam int AW = lfla_pkg::ADDR_W;

  state_e                 state_q, state_d;
  logic                   req_free_q, req_free_d;
  logic [IW-1:0]          free_index_q, free_index_d;
  logic [CW-1:0]          entries_in_use_q, entries_in_use_d;
  logic [CW-1:0]          free_head_q, free_head_d;
  logic [CW-1:0]          high_water_q, high_water_d;
  logic [CW-1:0]          alloc_count_q, alloc_count_d;
  logic                   out_valid_q, out_valid_d;
  lfla_pkg::status_e      status_q, status_d;
  logic [IW-1:0]          entry_index_q, entry_index_d;

  logic [CW-1:0]          link_mem [lfla_pkg::MAX_ENTRIES];
  logic [CW-1:0]          link_rd_q;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;

  logic                   in_acc;
  logic                   exec_go;
  logic [CW-1:0]          limit;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign exec_go       = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);
  assign limit         = (entries_in_use_q > CW'(lfla_pkg::LIMIT_CAP))
                       ? CW'(lfla_pkg::LIMIT_CAP) : entries_in_use_q;
  assign mem_waddr     = AW'(free_index_q);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {7'b0, alloc_count_q, entry_index_q};

  always_comb begin
    state_d          = state_q;
    req_free_d       = req_free_q;
    free_index_d     = free_index_q;
    entries_in_use_d = entries_in_use_q;
    free_head_d      = free_head_q;
    high_water_d     = high_water_q;
    alloc_count_d    = alloc_count_q;
    out_valid_d      = out_valid_q;
    status_d         = status_q;
    entry_index_d    = entry_index_q;
    mem_we           = 1'b0;

    if (cfg_we_i) begin
      entries_in_use_d = cfg_wdata_i;
    end
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_free_d   = (s_axis_tuser[0] == lfla_pkg::REQ_FREE);
          free_index_d = s_axis_tdata;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          out_valid_d   = 1'b1;
          status_d      = lfla_pkg::STAT_OK;
          entry_index_d = '0;
          state_d       = S_IDLE;
          if (!req_free_q) begin
            if (alloc_count_q >= limit) begin
              status_d = lfla_pkg::STAT_FULL;
            end else if (free_head_q == high_water_q) begin
              // Free list empty: hand out the next fresh entry.
              if (high_water_q >= limit) begin
                status_d = lfla_pkg::STAT_FULL;
              end else begin
                entry_index_d = IW'(high_water_q);
                high_water_d  = high_water_q + CW'(1);
                free_head_d   = high_water_q + CW'(1);
                alloc_count_d = alloc_count_q + CW'(1);
              end
            end else if (int'(free_head_q) >= lfla_pkg::MAX_ENTRIES) begin
              status_d = lfla_pkg::STAT_FULL;
            end else begin
              // The link of the head was read when the request was accepted.
              entry_index_d = IW'(free_head_q);
              free_head_d   = link_rd_q;
              alloc_count_d = alloc_count_q + CW'(1);
            end
          end else begin
            if ({1'b0, free_index_q} >= limit) begin
              status_d = lfla_pkg::STAT_RANGE;
            end else if (alloc_count_q == '0) begin
              status_d = lfla_pkg::STAT_NONE;
            end else begin
              mem_we        = 1'b1;
              free_head_d   = {1'b0, free_index_q};
              alloc_count_d = alloc_count_q - CW'(1);
              if (alloc_count_q == CW'(1)) begin
                // Last entry returned: the pool starts over from its reset state.
                free_head_d  = '0;
                high_water_d = '0;
              end
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      entries_in_use_q <= CW'(256);
      free_head_q      <= '0;
      high_water_q     <= '0;
      alloc_count_q    <= '0;
      out_valid_q      <= 1'b0;
      req_free_q       <= 1'b0;
      free_index_q     <= '0;
      status_q         <= lfla_pkg::STAT_OK;
      entry_index_q    <= '0;
    end else begin
      state_q          <= state_d;
      entries_in_use_q <= entries_in_use_d;
      free_head_q      <= free_head_d;
      high_water_q     <= high_water_d;
      alloc_count_q    <= alloc_count_d;
      out_valid_q      <= out_valid_d;
      req_free_q       <= req_free_d;
      free_index_q     <= free_index_d;
      status_q         <= status_d;
      entry_index_q    <= entry_index_d;
    end
  end

  // The head link is read at accept; the head only changes when the request executes in S_EXEC.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= free_head_q;
    end
    if (in_acc) begin
      link_rd_q <= link_mem[AW'(free_head_q)];
    end
  end

  `LFLA_ASSERT_IMPL(a_empty_pool_reset, alloc_count_q == '0, free_head_q == '0 && high_water_q == '0, "pool empty but list state not cleared")
  `LFLA_ASSERT_NEXT(a_reject_holds_count, exec_go && status_d != lfla_pkg::STAT_OK, $stable(alloc_count_q), "rejected request changed the count")
  `LFLA_ASSERT_NEXT(a_alloc_counts_up, exec_go && !req_free_q && status_d == lfla_pkg::STAT_OK, alloc_count_q == $past(alloc_count_q) + CW'(1), "allocate did not count up")
  `LFLA_ASSERT(a_count_bounded, alloc_count_q <= CW'(lfla_pkg::LIMIT_CAP) && high_water_q <= CW'(lfla_pkg::LIMIT_CAP), "count or high-water mark beyond pool")

endmodule

`default_nettype wire

[test/allocator_checker.sv]
`default_nettype none

module allocator_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [lfla_pkg::CNT_W-1:0] cfg_wdata_i,
  input  wire logic                       s_axis_tvalid,
  input  wire logic                       s_axis_tready,
  input  wire logic [lfla_pkg::IDX_W-1:0] s_axis_tdata,   // [7:0] free_index
  input  wire logic [0:0]                 s_axis_tuser,   // [0] req_type
  input  wire logic                       m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  input  wire logic [23:0]                m_axis_tdata,   // [7:0] entry_index,
                                                          // [16:8] allocated_count
  input  wire logic [1:0]                 m_axis_tuser,   // [1:0] status
  output int                              fail_count,
  output int                              pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import lfla_pkg::*;

  typedef struct packed {
    status_e              status;
    logic [IDX_W-1:0]     entry;
    logic [CNT_W-1:0]     count;
  } grant_t;

  // Links are kept 9 bits wide so that a link can name the high-water mark 256.
  logic [CNT_W-1:0] link_mem [MAX_ENTRIES];
  logic [CNT_W-1:0] head;
  logic [CNT_W-1:0] mark;
  logic [CNT_W-1:0] in_use;
  logic [CNT_W-1:0] pool_size;
  grant_t           expected_grants[$];
  int               mismatches;

  function automatic grant_t predict_grant(req_e req, logic [IDX_W-1:0] idx);
    grant_t g;
    int     limit;
    limit    = (pool_size > LIMIT_CAP) ? LIMIT_CAP : int'(pool_size);
    g.status = STAT_OK;
    g.entry  = '0;
    if (req == REQ_ALLOC) begin
      if (in_use >= limit) begin
        g.status = STAT_FULL;
      end else if (head == mark) begin
        // The free list is empty, so a fresh entry comes from the high-water mark.
        if (mark >= limit) begin
          g.status = STAT_FULL;
        end else begin
          g.entry = mark[IDX_W-1:0];
          mark    = mark + 1'b1;
          head    = mark;
          in_use  = in_use + 1'b1;
        end
      end else if (head >= MAX_ENTRIES) begin
        g.status = STAT_FULL;
      end else begin
        g.entry = head[IDX_W-1:0];
        head    = link_mem[head[ADDR_W-1:0]];
        in_use  = in_use + 1'b1;
      end
    end else begin
      if (idx >= limit) begin
        g.status = STAT_RANGE;
      end else if (in_use == 0) begin
        g.status = STAT_NONE;
      end else begin
        link_mem[idx] = head;
        head          = {1'b0, idx};
        in_use        = in_use - 1'b1;
        if (in_use == 0) begin
          head = '0;
          mark = '0;
        end
      end
    end
    g.count = in_use;
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ENTRIES; i++) link_mem[i] = '0;
      head       = '0;
      mark       = '0;
      in_use     = '0;
      pool_size  = CNT_W'(256);
      mismatches = 0;
      expected_grants.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_grants.size() == 0) begin
          $display("%0t: result transaction with no request pending: status %0d entry %0d count %0d",
                   $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[16:8]);
          mismatches++;
        end else begin
          want = expected_grants.pop_front();
          if (m_axis_tuser !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tdata[7:0] !== want.entry) begin
            $display("%0t: entry_index expected %0d actual %0d",
                     $time, want.entry, m_axis_tdata[7:0]);
            mismatches++;
          end
          if (m_axis_tdata[16:8] !== want.count) begin
            $display("%0t: allocated_count expected %0d actual %0d",
                     $time, want.count, m_axis_tdata[16:8]);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) pool_size = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_grants.push_back(predict_grant(req_e'(s_axis_tuser[0]), s_axis_tdata));
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_grants.size();
  end

endmodule

`default_nettype wire

[test/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lfla_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IDX_W-1:0] s_axis_tdata  = '0;
  logic [0:0]       s_axis_tuser  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [23:0]      m_axis_tdata;
  logic [1:0]       m_axis_tuser;

  int               fail_count;
  int               pending_count;
  int               cycles        = 0;
  int               sent          = 0;
  bit               calm          = 1'b0;
  bit               fill_done     = 1'b0;
  int               pool_size     = 256;
  logic [CNT_W-1:0] last_count    = '0;

  // Shadow of the well-formed traffic: entries held by the user, the free stack
  // and the high-water mark, used only to pick sensible indices to free.
  int               held[$];
  int               spare[$];
  int               mark          = 0;

  lazy_free_list_entry_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  allocator_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) last_count <= m_axis_tdata[16:8];
  end

  // Result side: random stalls, with occasional long windows of steady acceptance.
  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 19) < 4) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else if ($urandom_range(0, 19) == 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_request(req_e req, logic [IDX_W-1:0] idx);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= idx;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Waits until every request has its result, then lets the block go quiet.
  task automatic settle();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_pool_size(logic [CNT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pool_size    = (value > LIMIT_CAP) ? LIMIT_CAP : int'(value);
  endtask

  // Frees index 0 once per allocated entry; the last free returns the pool to
  // its reset state. Needs a pool size of at least one.
  task automatic empty_pool();
    int n;
    settle();
    n = last_count;
    repeat (n) send_request(REQ_FREE, '0);
    held.delete();
    spare.delete();
    mark = 0;
  endtask

  task automatic run_episode(int len);
    int pos;
    int idx;
    empty_pool();
    repeat (len) begin
      if (held.size() > 0 && ($urandom_range(0, 99) < 45 ||
          (held.size() >= pool_size && $urandom_range(0, 99) < 85))) begin
        pos = $urandom_range(0, held.size() - 1);
        idx = held[pos];
        held.delete(pos);
        spare.push_front(idx);
        if (held.size() == 0) begin
          spare.delete();
          mark = 0;
        end
        send_request(REQ_FREE, idx[IDX_W-1:0]);
      end else begin
        if (held.size() < pool_size) begin
          if (spare.size() > 0) begin
            held.push_back(spare.pop_front());
          end else begin
            held.push_back(mark);
            mark = mark + 1;
          end
        end
        send_request(REQ_ALLOC, '0);
      end
    end
  endtask

  // Arbitrary traffic: frees of any index, double frees, allocates past the limit.
  task automatic run_noise(int len);
    logic [IDX_W-1:0] idx;
    repeat (len) begin
      if ($urandom_range(0, 1) == 1) begin
        if ($urandom_range(0, 3) == 0 || pool_size == 0) begin
          idx = IDX_W'($urandom_range(0, 255));
        end else begin
          idx = IDX_W'($urandom_range(0, pool_size - 1));
        end
        send_request(REQ_FREE, idx);
      end else begin
        send_request(REQ_ALLOC, IDX_W'($urandom));
      end
    end
  endtask

  // Drives the high-water mark all the way to the end of a full-size pool.
  task automatic fill_pool();
    settle();
    set_pool_size(CNT_W'(256));
    empty_pool();
    repeat (257) send_request(REQ_ALLOC, '0);
    repeat (20) send_request(REQ_FREE, IDX_W'($urandom_range(0, 255)));
    repeat (25) send_request(REQ_ALLOC, '0);
    settle();
  endtask

  initial begin
    int               pick;
    logic [CNT_W-1:0] size_value;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting from the reset pool size of 256.
    send_request(REQ_FREE, 8'd0);      // nothing allocated
    send_request(REQ_ALLOC, 8'hff);
    send_request(REQ_ALLOC, 8'h00);
    send_request(REQ_FREE, 8'd0);
    send_request(REQ_ALLOC, 8'h5a);    // taken from the free list
    send_request(REQ_FREE, 8'd1);
    send_request(REQ_FREE, 8'd0);      // last entry freed, pool resets
    send_request(REQ_FREE, 8'd255);
    send_request(REQ_ALLOC, 8'h00);
    send_request(REQ_FREE, 8'd255);    // never handed out, still accepted
    settle();
    set_pool_size(CNT_W'(2));
    send_request(REQ_ALLOC, 8'h00);
    send_request(REQ_ALLOC, 8'h00);
    send_request(REQ_ALLOC, 8'h00);    // pool full
    send_request(REQ_FREE, 8'd2);      // out of range
    send_request(REQ_FREE, 8'd1);
    send_request(REQ_FREE, 8'd1);      // double free goes unnoticed
    settle();
    set_pool_size(CNT_W'(0));
    send_request(REQ_ALLOC, 8'h00);
    send_request(REQ_FREE, 8'd0);
    settle();
    set_pool_size(CNT_W'(8));
    repeat (5) send_request(REQ_ALLOC, 8'h00);
    settle();
    // Limit lowered below the number of entries in use.
    set_pool_size(CNT_W'(3));
    send_request(REQ_ALLOC, 8'h00);
    send_request(REQ_FREE, 8'd7);
    settle();
    set_pool_size(CNT_W'(511));
    send_request(REQ_FREE, 8'd200);
    settle();

    while (sent < 980) begin
      if (sent > 800) calm = 1'b1;
      if (!fill_done && sent > 350) begin
        fill_pool();
        fill_done = 1'b1;
      end
      pick = $urandom_range(0, 11);
      case (pick)
        0:       size_value = CNT_W'(0);
        1:       size_value = CNT_W'(511);
        2:       size_value = CNT_W'(256);
        3:       size_value = CNT_W'(1);
        4:       size_value = CNT_W'($urandom_range(0, 511));
        default: size_value = CNT_W'($urandom_range(2, 16));
      endcase
      set_pool_size(size_value);
      if (pool_size > 0 && $urandom_range(0, 9) < 7) begin
        run_episode($urandom_range(10, 60));
      end else begin
        run_noise($urandom_range(5, 30));
      end
      settle();
    end

    settle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
